/* hdl/wqe_pkg.sv */
package wqe_pkg;

  localparam int TASK_FIELD_W = 8;

  typedef enum logic [1:0] {
    OP_WAIT     = 2'd0,
    OP_WAKE_ONE = 2'd1,
    OP_WAKE_ALL = 2'd2,
    OP_TIMEOUT  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ENQUEUED = 3'd0,
    ST_WOKEN    = 3'd1,
    ST_TIMEOUT  = 3'd2,
    ST_NONE     = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    op_t                     op;
    logic [TASK_FIELD_W-1:0] task_id;
  } in_t;

  typedef struct packed {
    logic [TASK_FIELD_W-1:0] woken_task;
    status_t                 status;
    logic                    last;
  } out_t;

  // result handed from the sequencer to the output register
  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

endpackage

/* hdl/wait_queue_engine.sv */
// channel | ports                          | beat moves
// in      | in_valid, in_ready, in_data    | op and task_id
// out     | out_valid, out_ready, out_data | woken_task, status, last
//
// wait: slot write, then the result. wake-one: head read, then a read/write pair per younger
// entry on the single queue ram port pair. timeout: a read and compare per entry scanned,
// then a read/write pair per entry shifted. wake-all: one beat per entry emitted.
// rst_n is synchronous and clears the count; slot contents are not cleared.
// a full output register stalls the sequencer; in_ready is low until an item is done.
module wait_queue_engine #(
  parameter int DEPTH        = 16,
  parameter int TASK_ID_BITS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  wqe_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output wqe_pkg::out_t out_data
);

  import wqe_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int ID_W = (TASK_ID_BITS < TASK_FIELD_W) ? TASK_ID_BITS : TASK_FIELD_W;

  res_t            res;
  logic            res_ready;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [ID_W-1:0] ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [ID_W-1:0] ram_rdata;

  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  wqe_ctrl #(
    .DEPTH(DEPTH),
    .ID_W (ID_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .res      (res),
    .res_ready(res_ready),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  wqe_ram #(
    .WIDTH(ID_W),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_ready) begin
      out_valid_nxt = res.valid;
      if (res.valid) begin
        out_data_nxt = res.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hdl/wqe_ram.sv */
module wqe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/wqe_ctrl.sv */
module wqe_ctrl #(
  parameter int DEPTH = 16,
  parameter int ID_W  = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  wqe_pkg::in_t             in_data,
  output wqe_pkg::res_t            res,
  input  logic                     res_ready,
  output logic                     ram_we,
  output logic [$clog2(DEPTH)-1:0] ram_waddr,
  output logic [ID_W-1:0]          ram_wdata,
  output logic                     ram_re,
  output logic [$clog2(DEPTH)-1:0] ram_raddr,
  input  logic [ID_W-1:0]          ram_rdata
);

  import wqe_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_ALL_EMIT,
    S_RES
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  logic [ID_W-1:0] res_task_r, res_task_nxt;
  status_t         res_status_r, res_status_nxt;

  logic [CW-1:0]   idx_inc;
  logic [ID_W-1:0] in_id;
  logic            all_last;

  assign idx_inc  = idx_r + CW'(1);
  assign in_id    = in_data.task_id[ID_W-1:0];
  assign all_last = (idx_inc == count_r);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    id_nxt         = id_r;
    res_task_nxt   = res_task_r;
    res_status_nxt = res_status_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r[AW-1:0];
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = idx_r[AW-1:0];
    res.valid      = 1'b0;
    res.data       = '{woken_task: TASK_FIELD_W'(res_task_r), status: res_status_r,
                       last: 1'b1};

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          id_nxt  = in_id;
          idx_nxt = '0;
          case (in_data.op)
            OP_WAIT: begin
              res_task_nxt = in_id;
              state_nxt    = S_RES;
              if (count_r == CW'(DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                ram_we         = 1'b1;
                ram_waddr      = count_r[AW-1:0];
                ram_wdata      = in_id;
                count_nxt      = count_r + CW'(1);
                res_status_nxt = ST_ENQUEUED;
              end
            end
            OP_WAKE_ONE, OP_WAKE_ALL: begin
              if (count_r == '0) begin
                res_task_nxt   = '0;
                res_status_nxt = ST_NONE;
                state_nxt      = S_RES;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                state_nxt = (in_data.op == OP_WAKE_ONE) ? S_HEAD : S_ALL_EMIT;
              end
            end
            OP_TIMEOUT: begin
              state_nxt = S_SCAN_RD;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_HEAD: begin
        res_task_nxt   = ram_rdata;
        res_status_nxt = ST_WOKEN;
        state_nxt      = S_SHIFT_RD;
      end
      // close the gap at idx, one entry per read/write pair
      S_SHIFT_RD: begin
        if (idx_inc < count_r) begin
          ram_re    = 1'b1;
          ram_raddr = idx_inc[AW-1:0];
          state_nxt = S_SHIFT_WR;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_RES;
        end
      end
      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_inc;
        state_nxt = S_SHIFT_RD;
      end
      S_SCAN_RD: begin
        if (idx_r < count_r) begin
          ram_re    = 1'b1;
          ram_raddr = idx_r[AW-1:0];
          state_nxt = S_SCAN_CMP;
        end else begin
          res_task_nxt   = '0;
          res_status_nxt = ST_NONE;
          state_nxt      = S_RES;
        end
      end
      S_SCAN_CMP: begin
        if (ram_rdata == id_r) begin
          res_task_nxt   = id_r;
          res_status_nxt = ST_TIMEOUT;
          state_nxt      = S_SHIFT_RD;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SCAN_RD;
        end
      end
      // one beat per queued entry, next read issued as the current one leaves
      S_ALL_EMIT: begin
        res.valid = 1'b1;
        res.data  = '{woken_task: TASK_FIELD_W'(ram_rdata), status: ST_WOKEN,
                      last: all_last};
        if (res_ready) begin
          if (all_last) begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_inc[AW-1:0];
            idx_nxt   = idx_inc;
          end
        end
      end
      S_RES: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
    id_r         <= id_nxt;
    res_task_r   <= res_task_nxt;
    res_status_r <= res_status_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("waiter count above depth");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT_WR |-> idx_inc < count_r)
    else $error("shift writes past the occupied range");

  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !res.valid)
    else $error("result offered while idle");

  a_enqueue_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.op == OP_WAIT && count_r != CW'(DEPTH)
    |=> count_r == $past(count_r) + CW'(1))
    else $error("enqueue did not grow the queue");

  a_wake_all_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ALL_EMIT && res_ready && all_last |=> count_r == '0)
    else $error("wake-all left entries behind");

endmodule

/* tb/wqe_checker.sv */
`timescale 1ns / 100ps

module wqe_checker #(
  parameter int DEPTH        = 16,
  parameter int TASK_ID_BITS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  wqe_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  wqe_pkg::out_t out_data,
  output int            fail_count,
  output int            pending
);
  import wqe_pkg::*;

  localparam int ID_MASK    = (1 << TASK_ID_BITS) - 1;
  localparam int MAX_REPORT = 10;

  logic [TASK_FIELD_W-1:0] waiters[$];
  out_t                    wake_results[$];
  int                      mismatch_count = 0;

  function automatic out_t make_result(logic [TASK_FIELD_W-1:0] tid, status_t st, logic lst);
    out_t r;
    r.woken_task = tid;
    r.status     = st;
    r.last       = lst;
    return r;
  endfunction

  // mirror of the queue: one beat in, its results appended in order
  function automatic void predict_beat(in_t beat);
    logic [TASK_FIELD_W-1:0] id;
    int                      hit;
    id  = beat.task_id & TASK_FIELD_W'(ID_MASK);
    hit = -1;
    case (beat.op)
      OP_WAIT: begin
        if (waiters.size() >= DEPTH) begin
          wake_results.push_back(make_result(id, ST_FULL, 1'b1));
        end else begin
          waiters.push_back(id);
          wake_results.push_back(make_result(id, ST_ENQUEUED, 1'b1));
        end
      end
      OP_WAKE_ONE: begin
        if (waiters.size() == 0) begin
          wake_results.push_back(make_result('0, ST_NONE, 1'b1));
        end else begin
          wake_results.push_back(make_result(waiters.pop_front(), ST_WOKEN, 1'b1));
        end
      end
      OP_WAKE_ALL: begin
        if (waiters.size() == 0) begin
          wake_results.push_back(make_result('0, ST_NONE, 1'b1));
        end else begin
          foreach (waiters[i]) begin
            wake_results.push_back(make_result(waiters[i], ST_WOKEN,
                                               i == waiters.size() - 1));
          end
          waiters.delete();
        end
      end
      OP_TIMEOUT: begin
        // only the oldest matching entry goes
        foreach (waiters[i]) begin
          if (hit < 0 && waiters[i] == id) hit = i;
        end
        if (hit >= 0) begin
          waiters.delete(hit);
          wake_results.push_back(make_result(id, ST_TIMEOUT, 1'b1));
        end else begin
          wake_results.push_back(make_result('0, ST_NONE, 1'b1));
        end
      end
      default: begin
        wake_results.push_back(make_result('0, ST_NONE, 1'b1));
      end
    endcase
  endfunction

  task automatic note_failure(string msg);
    if (mismatch_count < MAX_REPORT) $display("%s", msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      waiters.delete();
      wake_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (wake_results.size() == 0) begin
          note_failure($sformatf("unexpected result beat: task %0h status %0d last %0b",
                                 out_data.woken_task, out_data.status, out_data.last));
        end else begin
          want = wake_results.pop_front();
          if (out_data.woken_task !== want.woken_task || out_data.status !== want.status ||
              out_data.last !== want.last) begin
            note_failure($sformatf(
              "mismatch: expected task %0h status %0d last %0b, got task %0h status %0d last %0b",
              want.woken_task, want.status, want.last,
              out_data.woken_task, out_data.status, out_data.last));
          end
        end
      end
      if (in_valid && in_ready) predict_beat(in_data);
    end
    fail_count <= mismatch_count;
    pending    <= wake_results.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import wqe_pkg::*;

  localparam int DEPTH        = 16;
  localparam int TASK_ID_BITS = 8;
  localparam int RANDOM_ITEMS = 384;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 600000;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int fail_count;
  int pending;
  int send_idle = 35;
  int recv_idle = 85;
  int phase     = 0;
  int cycle_cnt = 0;

  wait_queue_engine #(
    .DEPTH        (DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  wqe_checker #(
    .DEPTH        (DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  // result side: random stalls plus one long hold-off when the last phase starts
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (phase == 2 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_beat(op_t op, logic [TASK_FIELD_W-1:0] id);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{op: op, task_id: id};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic op_t pick_op(bit filling);
    int r;
    r = $urandom_range(99);
    if (filling) begin
      if (r < 65) return OP_WAIT;
      if (r < 75) return OP_WAKE_ONE;
      if (r < 95) return OP_TIMEOUT;
      return OP_WAKE_ALL;
    end
    if (r < 30) return OP_WAIT;
    if (r < 60) return OP_WAKE_ONE;
    if (r < 85) return OP_TIMEOUT;
    return OP_WAKE_ALL;
  endfunction

  // a small id pool makes timeouts hit queued tasks and duplicates common
  function automatic logic [TASK_FIELD_W-1:0] pick_id();
    if ($urandom_range(99) < 60) return TASK_FIELD_W'($urandom_range(7));
    return TASK_FIELD_W'($urandom_range(255));
  endfunction

  initial begin
    int  n;
    bit  filling;
    logic [TASK_FIELD_W-1:0] fill_id;
    filling = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue on every op that reads it
    send_beat(OP_WAKE_ONE, 8'h00);
    send_beat(OP_WAKE_ALL, 8'hFF);
    send_beat(OP_TIMEOUT, 8'h00);
    // fill up with extremes and a duplicate, then overflow
    for (n = 0; n < DEPTH; n++) begin
      if (n == 0) fill_id = 8'h00;
      else if (n < 3) fill_id = 8'hFF;
      else fill_id = TASK_FIELD_W'(8'h10 + n);
      send_beat(OP_WAIT, fill_id);
    end
    send_beat(OP_WAIT, 8'h42);
    send_beat(OP_TIMEOUT, 8'hFF);
    send_beat(OP_TIMEOUT, 8'h1F);
    send_beat(OP_TIMEOUT, 8'h00);
    send_beat(OP_TIMEOUT, 8'hAA);
    send_beat(OP_WAKE_ONE, 8'h00);
    send_beat(OP_WAKE_ALL, 8'h00);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle = 85;
        recv_idle = 35;
        phase     = 1;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle = 0;
        recv_idle = 0;
        phase     = 2;
      end
      if (n % 24 == 0) filling = 1'($urandom_range(1));
      send_beat(pick_op(filling), pick_id());
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* wait_queue_engine.f */
hdl/wqe_pkg.sv
hdl/wqe_ram.sv
hdl/wqe_ctrl.sv
hdl/wait_queue_engine.sv
tb/wqe_checker.sv
tb/testbench.sv
